// ===== rtl/gdcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gdcd_pkg
// Shared types, constants and calendar tables for the date compare/diff unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gdcd_pkg;

  localparam int DayW   = 5;
  localparam int MonW   = 4;
  localparam int YearW  = 14;
  localparam int DnumW  = 23;   // day number from 0000-01-01, years up to 16383
  localparam int DiffW  = 22;

  // highest year that still counts as a valid date
  localparam logic [15:0] YearMax = 16'd9999;

  // x / 100 == (x * 5243) >> 19 for every x below 43699
  localparam int          Div100MulW  = 13;
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int          Div100Shift = 19;
  localparam int          QuotW       = 8;   // quotients stay below 256
  localparam int          ProdW       = 28;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_EARLIER = 2'd1,
    ORD_LATER   = 2'd2
  } gdcd_order_e;

  typedef struct packed {
    logic [DayW-1:0]  day_first;
    logic [MonW-1:0]  month_first;
    logic [YearW-1:0] year_first;
    logic [DayW-1:0]  day_second;
    logic [MonW-1:0]  month_second;
    logic [YearW-1:0] year_second;
  } gdcd_in_t;

  typedef struct packed {
    logic             first_valid;
    logic             second_valid;
    logic             first_leap;
    logic             second_leap;
    logic [1:0]       order;
    logic [DiffW-1:0] days_apart;
  } gdcd_out_t;

  // load enables of the three date-conversion stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } gdcd_pipe_en_t;

  // month length, zero for a month code outside 1..12
  function automatic logic [DayW-1:0] month_len(logic [MonW-1:0] m, logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                  len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default:                                  len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [8:0] days_before(logic [MonW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gdcd_day_num.sv =====
// ----------------------------------------------------------------------------
// gdcd_day_num
// Three-stage conversion of one date into validity, leap flag and day number.
// ----------------------------------------------------------------------------
`default_nettype none

module gdcd_day_num import gdcd_pkg::*; (
  input  wire logic                clk_i,
  input  wire gdcd_pipe_en_t       en_i,
  input  wire logic [DayW-1:0]     day_i,
  input  wire logic [MonW-1:0]     month_i,
  input  wire logic [YearW-1:0]    year_i,
  output logic                     valid_o,
  output logic                     leap_o,
  output logic [DnumW-1:0]         dnum_o
);

  // stage 1: reciprocal multiplies for the century terms, 365 * year
  logic [YearW:0]      yp99, yp399;
  logic [ProdW-1:0]    py_d, p100_d, p400_d;
  logic [QuotW-1:0]    qy_q, q100_q, q400_q;
  logic [DnumW-1:0]    y365_d, y365_q;
  logic [YearW-1:0]    y1_q;
  logic [MonW-1:0]     m1_q;
  logic [DayW-1:0]     d1_q;

  assign yp99   = {1'b0, year_i} + 15'd99;
  assign yp399  = {1'b0, year_i} + 15'd399;
  assign py_d   = ProdW'(year_i) * ProdW'(Div100Mul);
  assign p100_d = ProdW'(yp99) * ProdW'(Div100Mul);
  assign p400_d = ProdW'(yp399[YearW:2]) * ProdW'(Div100Mul);   // ((y+399)/4)/100
  assign y365_d = DnumW'(year_i) * DnumW'(365);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      qy_q   <= py_d[Div100Shift +: QuotW];
      q100_q <= p100_d[Div100Shift +: QuotW];
      q400_q <= p400_d[Div100Shift +: QuotW];
      y365_q <= y365_d;
      y1_q   <= year_i;
      m1_q   <= month_i;
      d1_q   <= day_i;
    end
  end

  // stage 2: leap rule, validity, year part of the day number
  logic [YearW-1:0]    rem100;
  logic [YearW:0]      yp3;
  logic                leap_d, valid_d;
  logic [DayW-1:0]     mlen;
  logic [DnumW-1:0]    base_d, base_q;
  logic                leap2_q, valid2_q;
  logic [MonW-1:0]     m2_q;
  logic [DayW-1:0]     d2_q;

  assign rem100  = y1_q - YearW'(YearW'(qy_q) * YearW'(100));
  assign leap_d  = (y1_q[1:0] == 2'b00) && ((rem100 != '0) || (qy_q[1:0] == 2'b00));
  assign mlen    = month_len(m1_q, leap_d);
  assign valid_d = (d1_q != '0) && (d1_q <= mlen) && ({2'b00, y1_q} <= YearMax);
  assign yp3     = {1'b0, y1_q} + 15'd3;
  assign base_d  = y365_q + DnumW'(yp3[YearW:2]) - DnumW'(q100_q) + DnumW'(q400_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      base_q   <= base_d;
      leap2_q  <= leap_d;
      valid2_q <= valid_d;
      m2_q     <= m1_q;
      d2_q     <= d1_q;
    end
  end

  // stage 3: month and day part
  logic [DnumW-1:0] dnum_d, dnum_q;
  logic             leap3_q, valid3_q;

  assign dnum_d = base_q + DnumW'(days_before(m2_q))
                + DnumW'(leap2_q && (m2_q > 4'd2)) + DnumW'(d2_q) - DnumW'(1);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      dnum_q   <= dnum_d;
      leap3_q  <= leap2_q;
      valid3_q <= valid2_q;
    end
  end

  assign valid_o = valid3_q;
  assign leap_o  = leap3_q;
  assign dnum_o  = dnum_q;

endmodule

`default_nettype wire

// ===== rtl/gregorian_date_compare_and_diff_unit.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_compare_and_diff_unit
// Checks two Gregorian dates, orders them and gives the days between them.
// ----------------------------------------------------------------------------
// One item per clock cycle is taken while the input is not stalled, and each
// result is written to the output register. Each date runs through
// three register stages (century quotients by reciprocal multiply, then leap
// rule and year count, then month and day count); a fourth stage forms the
// absolute difference. Every stage holds its own valid bit and loads whenever
// it is empty or the stage after it moves, so bubbles close up under a stall
// and the input stall only rises once all four stages hold items. Validity
// accepts years 0..9999 (year 0 is a leap year); days_apart is 0 whenever
// either date is invalid, and the order compares the raw (year, month, day).
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_compare_and_diff_unit import gdcd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire gdcd_in_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output gdcd_out_t      out_item_o
);

  // stage valid bits, stage 4 is the output register
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy4;
  gdcd_pipe_en_t en;

  // a stage loads when it is empty or its successor moves on
  assign rdy4 = !out_valid_q || !out_stall_i;
  assign rdy3 = !s3_valid_q || rdy4;
  assign rdy2 = !s2_valid_q || rdy3;
  assign rdy1 = !s1_valid_q || rdy2;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q  <= in_valid_i;
      if (rdy2) s2_valid_q  <= s1_valid_q;
      if (rdy3) s3_valid_q  <= s2_valid_q;
      if (rdy4) out_valid_q <= s3_valid_q;
    end
  end

  // per-date conversion pipes
  logic             v_first, v_second, lp_first, lp_second;
  logic [DnumW-1:0] n_first, n_second;

  gdcd_day_num u_first (
    .clk_i   (clk_i),
    .en_i    (en),
    .day_i   (in_item_i.day_first),
    .month_i (in_item_i.month_first),
    .year_i  (in_item_i.year_first),
    .valid_o (v_first),
    .leap_o  (lp_first),
    .dnum_o  (n_first)
  );

  gdcd_day_num u_second (
    .clk_i   (clk_i),
    .en_i    (en),
    .day_i   (in_item_i.day_second),
    .month_i (in_item_i.month_second),
    .year_i  (in_item_i.year_second),
    .valid_o (v_second),
    .leap_o  (lp_second),
    .dnum_o  (n_second)
  );

  // order from raw fields, year most significant, carried alongside the pipes
  localparam int KeyW = YearW + MonW + DayW;
  logic [KeyW-1:0] key_first, key_second;
  gdcd_order_e     ord_d, ord1_q, ord2_q, ord3_q;

  assign key_first  = {in_item_i.year_first, in_item_i.month_first, in_item_i.day_first};
  assign key_second = {in_item_i.year_second, in_item_i.month_second, in_item_i.day_second};

  always_comb begin
    if (key_first == key_second) begin
      ord_d = ORD_EQUAL;
    end else if (key_first < key_second) begin
      ord_d = ORD_EARLIER;
    end else begin
      ord_d = ORD_LATER;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) ord1_q <= ord_d;
    if (en.s2) ord2_q <= ord1_q;
    if (en.s3) ord3_q <= ord2_q;
  end

  // stage 4: absolute difference, forced to zero for an invalid date
  logic [DnumW-1:0] diff_abs;
  gdcd_out_t        out_d, out_q;

  assign diff_abs = (n_first >= n_second) ? (n_first - n_second) : (n_second - n_first);

  always_comb begin
    out_d.first_valid  = v_first;
    out_d.second_valid = v_second;
    out_d.first_leap   = lp_first;
    out_d.second_leap  = lp_second;
    out_d.order        = ord3_q;
    out_d.days_apart   = (v_first && v_second) ? diff_abs[DiffW-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  // an accepted item always lands in the first stage
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted item missing from stage 1");

  // the input only stalls when the first stage holds an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty stage 1");

  // an invalid date yields no day count
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (!out_item_o.first_valid || !out_item_o.second_valid))
      |-> (out_item_o.days_apart == '0))
    else $error("nonzero difference with an invalid date");

  // identical dates are zero days apart
  a_equal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.order == ORD_EQUAL)) |-> (out_item_o.days_apart == '0))
    else $error("equal dates with nonzero difference");
`endif

endmodule

`default_nettype wire
